/* design/hrf_pkg.sv */
// ---------------------------------------------------------------------------
// hrf_pkg
// Shared types, constants and helpers for the HSV to RGB565 fog pipeline.
// ---------------------------------------------------------------------------
package hrf_pkg;

	localparam int FOG_DEPTHS_DEF = 8;

	localparam logic [7:0] SECTOR_SPAN = 8'd43;
	localparam logic [3:0] REM_SCALE   = 4'd6;
	localparam logic [7:0] FULL_LEVEL  = 8'd255;
	localparam logic [7:0] FOG_STEP    = 8'd34;
	localparam logic [4:0] MASK5       = 5'h1F;
	localparam logic [5:0] MASK6       = 6'h3F;

	// hue sector codes
	localparam logic [2:0] REG_RED_YEL = 3'd0;
	localparam logic [2:0] REG_YEL_GRN = 3'd1;
	localparam logic [2:0] REG_GRN_CYN = 3'd2;
	localparam logic [2:0] REG_CYN_BLU = 3'd3;
	localparam logic [2:0] REG_BLU_MAG = 3'd4;
	localparam logic [2:0] REG_MAG_RED = 3'd5;

	typedef struct packed {
		logic [2:0] fog_level;
		logic [7:0] brightness;
		logic [7:0] saturation;
		logic [7:0] hue;
	} pix_in_t;

	// after sector split
	typedef struct packed {
		logic [2:0]  region;
		logic [7:0]  rem;
		logic [7:0]  sat;
		logic [7:0]  val;
		logic [2:0]  fog;
		logic [15:0] p_prod;
	} sect_t;

	// after the scaled saturation terms
	typedef struct packed {
		logic [2:0] region;
		logic [7:0] sq;
		logic [7:0] st;
		logic [7:0] p;
		logic [7:0] val;
		logic [2:0] fog;
	} sterm_t;

	// channel levels ready for selection
	typedef struct packed {
		logic [2:0] region;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
		logic [7:0] val;
		logic [2:0] fog;
	} lvl_t;

	function automatic logic [7:0] fog_scale(input logic [2:0] lvl);
		logic [8:0] prod;
		prod = 9'(lvl) * 9'(FOG_STEP);
		return 8'(9'(FULL_LEVEL) - prod);
	endfunction

endpackage

/* design/hrf_sector.sv */
// ---------------------------------------------------------------------------
// hrf_sector
// First stage: hue sector, scaled remainder and the p product.
// ---------------------------------------------------------------------------
module hrf_sector (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hrf_pkg::pix_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output hrf_pkg::sect_t   out_data
);

	logic           valid_s1;
	hrf_pkg::sect_t data_s1;
	hrf_pkg::sect_t nxt;
	logic [2:0]     region;
	logic [7:0]     base_h;
	logic [5:0]     off;
	logic           en;

	// compare chain in place of a divide by 43
	always_comb begin
		if (in_data.hue >= 8'd215) begin
			region = hrf_pkg::REG_MAG_RED;
		end else if (in_data.hue >= 8'd172) begin
			region = hrf_pkg::REG_BLU_MAG;
		end else if (in_data.hue >= 8'd129) begin
			region = hrf_pkg::REG_CYN_BLU;
		end else if (in_data.hue >= 8'd86) begin
			region = hrf_pkg::REG_GRN_CYN;
		end else if (in_data.hue >= 8'd43) begin
			region = hrf_pkg::REG_YEL_GRN;
		end else begin
			region = hrf_pkg::REG_RED_YEL;
		end
		base_h = 8'(11'(region) * 11'(hrf_pkg::SECTOR_SPAN));
		off = 6'(in_data.hue - base_h);
		nxt.region = region;
		nxt.rem    = 8'(9'(off) * 9'(hrf_pkg::REM_SCALE));
		nxt.sat    = in_data.saturation;
		nxt.val    = in_data.brightness;
		nxt.fog    = in_data.fog_level;
		nxt.p_prod = in_data.brightness * (hrf_pkg::FULL_LEVEL - in_data.saturation);
	end

	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* design/hrf_level.sv */
// ---------------------------------------------------------------------------
// hrf_level
// Two stages: saturation-scaled terms, then the q and t levels.
// ---------------------------------------------------------------------------
module hrf_level (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hrf_pkg::sect_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output hrf_pkg::lvl_t  out_data
);

	logic            valid_s2, valid_s3;
	hrf_pkg::sterm_t data_s2;
	hrf_pkg::lvl_t   data_s3;
	logic            en2, en3;
	logic [15:0]     prod_q, prod_t;
	logic [15:0]     lvl_q, lvl_t;

	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign in_ready = en2;

	assign prod_q = in_data.sat * in_data.rem;
	assign prod_t = in_data.sat * (hrf_pkg::FULL_LEVEL - in_data.rem);
	assign lvl_q  = data_s2.val * (hrf_pkg::FULL_LEVEL - data_s2.sq);
	assign lvl_t  = data_s2.val * (hrf_pkg::FULL_LEVEL - data_s2.st);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en2) begin
				valid_s2 <= in_valid;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && in_valid) begin
			data_s2.region <= in_data.region;
			data_s2.sq     <= prod_q[15:8];
			data_s2.st     <= prod_t[15:8];
			data_s2.p      <= in_data.p_prod[15:8];
			data_s2.val    <= in_data.val;
			data_s2.fog    <= in_data.fog;
		end
		if (en3 && valid_s2) begin
			data_s3.region <= data_s2.region;
			data_s3.p      <= data_s2.p;
			data_s3.q      <= lvl_q[15:8];
			data_s3.t      <= lvl_t[15:8];
			data_s3.val    <= data_s2.val;
			data_s3.fog    <= data_s2.fog;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

/* design/hrf_fog.sv */
// ---------------------------------------------------------------------------
// hrf_fog
// Two stages: channel select and RGB565 pack, then fog attenuation.
// ---------------------------------------------------------------------------
module hrf_fog #(
	parameter int FOG_DEPTHS = hrf_pkg::FOG_DEPTHS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hrf_pkg::lvl_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [15:0]   base_color,
	output logic [15:0]   fogged_color
);

	localparam logic [3:0] DEPTH_W = 4'(FOG_DEPTHS);
	localparam logic [2:0] LAST_LV = 3'(FOG_DEPTHS - 1);

	logic        valid_s4, valid_s5;
	logic [15:0] base_s4;
	logic [7:0]  k_s4;
	logic [15:0] base_s5, fog_s5;
	logic        en4, en5;
	logic [7:0]  r, g, b;
	logic [2:0]  lvl;
	logic [12:0] r_m, b_m;
	logic [13:0] g_m;

	assign en5      = !valid_s5 || out_ready;
	assign en4      = !valid_s4 || en5;
	assign in_ready = en4;

	always_comb begin
		case (in_data.region)
			hrf_pkg::REG_RED_YEL: begin
				r = in_data.val; g = in_data.t;   b = in_data.p;
			end
			hrf_pkg::REG_YEL_GRN: begin
				r = in_data.q;   g = in_data.val; b = in_data.p;
			end
			hrf_pkg::REG_GRN_CYN: begin
				r = in_data.p;   g = in_data.val; b = in_data.t;
			end
			hrf_pkg::REG_CYN_BLU: begin
				r = in_data.p;   g = in_data.q;   b = in_data.val;
			end
			hrf_pkg::REG_BLU_MAG: begin
				r = in_data.t;   g = in_data.p;   b = in_data.val;
			end
			default: begin
				r = in_data.val; g = in_data.p;   b = in_data.q;
			end
		endcase
		// levels past the last depth saturate
		if ({1'b0, in_data.fog} >= DEPTH_W) begin
			lvl = LAST_LV;
		end else begin
			lvl = in_data.fog;
		end
	end

	assign r_m = base_s4[15:11] * k_s4;
	assign g_m = base_s4[10:5] * k_s4;
	assign b_m = base_s4[4:0] * k_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en4) begin
				valid_s4 <= in_valid;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			base_s4 <= {r[7:3], g[7:2], b[7:3]};
			k_s4    <= hrf_pkg::fog_scale(lvl);
		end
		if (en5 && valid_s4) begin
			base_s5 <= base_s4;
			fog_s5  <= {r_m[12:8] & hrf_pkg::MASK5, g_m[13:8] & hrf_pkg::MASK6,
				b_m[12:8] & hrf_pkg::MASK5};
		end
	end

	assign out_valid    = valid_s5;
	assign base_color   = base_s5;
	assign fogged_color = fog_s5;

endmodule

/* design/hsv_to_rgb565_fog.sv */
// path: an input pixel is registered through stages s1 to s5 to the master side
// throughput: one pixel per cycle; each of the five stages holds while the
//   stage after it is full and stalled, and accepts again once it drains
// reset: arst_n clears all stage valid bits asynchronously; data is not reset
// ---------------------------------------------------------------------------
// hsv_to_rgb565_fog
// HSV to RGB565 conversion with a fogged copy of each pixel.
// ---------------------------------------------------------------------------
module hsv_to_rgb565_fog #(
	parameter int FOG_DEPTHS = hrf_pkg::FOG_DEPTHS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // hue, saturation, brightness, fog_level, pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // base_color, fogged_color
);

	hrf_pkg::pix_in_t pix;
	hrf_pkg::sect_t   sect;
	hrf_pkg::lvl_t    lvl;
	logic             sect_valid, sect_ready;
	logic             lvl_valid, lvl_ready;
	logic [15:0]      base_color, fogged_color;

	assign pix = hrf_pkg::pix_in_t'(s_axis_tdata[26:0]);

	hrf_sector u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (pix),
		.out_valid (sect_valid),
		.out_ready (sect_ready),
		.out_data  (sect)
	);

	hrf_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sect_valid),
		.in_ready  (sect_ready),
		.in_data   (sect),
		.out_valid (lvl_valid),
		.out_ready (lvl_ready),
		.out_data  (lvl)
	);

	hrf_fog #(
		.FOG_DEPTHS (FOG_DEPTHS)
	) u_fog (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (lvl_valid),
		.in_ready     (lvl_ready),
		.in_data      (lvl),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.base_color   (base_color),
		.fogged_color (fogged_color)
	);

	assign m_axis_tdata = {fogged_color, base_color};

`ifndef NO_ASSERTIONS
	// a ready sink never backs up the pipeline
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("pipeline blocked while sink ready");

	// an accepted pixel always lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> sect_valid)
		else $error("input transfer lost");

	// fog only darkens each channel
	a_fog_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (fogged_color[15:11] <= base_color[15:11]) &&
			(fogged_color[10:5] <= base_color[10:5]) &&
			(fogged_color[4:0] <= base_color[4:0]))
		else $error("fogged channel brighter than base");
`endif

endmodule
